>>> rtl/srd_pkg.sv
// types and constants shared by the sprite run-length decoder
package srd_pkg;

	localparam int unsigned LenW = 20;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_FILL    = 4'b0010,
		PH_LENGTH  = 4'b0100,
		PH_LITERAL = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_LIT   = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_TRANS = 2'd2
	} kind_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SKIP  = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	typedef struct packed {
		logic [7:0]      pixel_value;
		logic [LenW-1:0] run_length;
		logic [1:0]      status;
		logic            image_done;
	} run_t;

endpackage

>>> rtl/srd_if.sv
// channel interfaces for compressed bytes and decoded runs
interface srd_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       final_byte;

	modport source (output valid, output code_byte, output final_byte, input ready);
	modport sink (input valid, input code_byte, input final_byte, output ready);
endinterface

interface srd_run_if;
	logic                      valid;
	logic                      ready;
	logic [7:0]                pixel_value;
	logic [srd_pkg::LenW-1:0]  run_length;
	logic [1:0]                status;
	logic                      image_done;

	modport source (output valid, output pixel_value, output run_length, output status,
		output image_done, input ready);
	modport sink (input valid, input pixel_value, input run_length, input status,
		input image_done, output ready);
endinterface

>>> rtl/srd_parser.sv
// token parser: state registers and next-state logic for one byte per step
module srd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        code_byte,
	input  logic              final_byte,
	input  logic [7:0]        transparent_index,
	output logic              emit,
	output srd_pkg::run_t     res
);

	srd_pkg::phase_t           phase_q, phase_d;
	srd_pkg::kind_t            kind_q, kind_d;
	logic [1:0]                left_q, left_d;
	logic [srd_pkg::LenW-1:0]  acc_q, acc_d;
	logic [7:0]                fill_q, fill_d;
	logic [srd_pkg::LenW-1:0]  lit_q, lit_d;
	logic [3:0]                hi;
	logic                      len_done;
	logic                      known;

	assign hi = code_byte[7:4];

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		left_d   = left_q;
		acc_d    = acc_q;
		fill_d   = fill_q;
		lit_d    = lit_q;
		emit     = 1'b0;
		len_done = 1'b0;
		known    = 1'b1;
		res      = '0;

		unique case (phase_q)
			srd_pkg::PH_HEADER: begin
				case (hi) inside
					4'h0, 4'h1, 4'h2: kind_d = srd_pkg::KIND_LIT;
					4'h8, 4'h9, 4'hA: kind_d = srd_pkg::KIND_FILL;
					4'hC, 4'hD, 4'hE: kind_d = srd_pkg::KIND_TRANS;
					default:          known  = 1'b0;
				endcase
				if (!known) begin
					res.status = srd_pkg::ST_SKIP;
					emit       = 1'b1;
				end else begin
					acc_d  = {{(srd_pkg::LenW-4){1'b0}}, code_byte[3:0]};
					left_d = hi[1:0];
					if (kind_d == srd_pkg::KIND_FILL) begin
						phase_d = srd_pkg::PH_FILL;
					end else if (hi[1:0] != 2'd0) begin
						phase_d = srd_pkg::PH_LENGTH;
					end else begin
						len_done = 1'b1;
					end
				end
			end
			srd_pkg::PH_FILL: begin
				fill_d = code_byte;
				if (left_q != 2'd0) begin
					phase_d = srd_pkg::PH_LENGTH;
				end else begin
					len_done = 1'b1;
				end
			end
			srd_pkg::PH_LENGTH: begin
				acc_d  = {acc_q[srd_pkg::LenW-9:0], code_byte};
				left_d = (left_q != 2'd0) ? left_q - 2'd1 : 2'd0;
				if (left_d == 2'd0) begin
					len_done = 1'b1;
				end
			end
			srd_pkg::PH_LITERAL: begin
				res.pixel_value = code_byte;
				res.run_length  = {{(srd_pkg::LenW-1){1'b0}}, 1'b1};
				emit            = 1'b1;
				lit_d = (lit_q != '0) ? lit_q - {{(srd_pkg::LenW-1){1'b0}}, 1'b1} : '0;
				if (lit_d == '0) begin
					phase_d = srd_pkg::PH_HEADER;
				end
			end
			default: phase_d = srd_pkg::PH_HEADER;
		endcase

		// length complete: zero drops, literal opens its bytes, others emit
		if (len_done) begin
			phase_d = srd_pkg::PH_HEADER;
			if (acc_d != '0) begin
				if (kind_d == srd_pkg::KIND_LIT) begin
					lit_d   = acc_d;
					phase_d = srd_pkg::PH_LITERAL;
				end else begin
					res.pixel_value = (kind_d == srd_pkg::KIND_FILL) ? fill_d : transparent_index;
					res.run_length  = acc_d;
					emit            = 1'b1;
				end
			end
		end

		if (final_byte) begin
			if (phase_d != srd_pkg::PH_HEADER) begin
				res.status = srd_pkg::ST_TRUNC;
			end
			res.image_done = 1'b1;
			emit    = 1'b1;
			phase_d = srd_pkg::PH_HEADER;
			kind_d  = srd_pkg::KIND_LIT;
			left_d  = '0;
			acc_d   = '0;
			fill_d  = '0;
			lit_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srd_pkg::PH_HEADER;
			kind_q  <= srd_pkg::KIND_LIT;
			left_q  <= '0;
			acc_q   <= '0;
			fill_q  <= '0;
			lit_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			fill_q  <= fill_d;
			lit_q   <= lit_d;
		end
	end

endmodule

>>> rtl/sprite_rle_decoder.sv
// Sprite run-length decoder top level. One compressed byte is taken per cycle
// on the code channel; each byte advances the token parser once and yields at
// most one run (pixel value, length, status, done) on the runs channel, via
// the input and result registers. Sustained rate is one byte per clock, set by
// the single-pass parser step between those registers; input stalls only while
// the result register holds a run not yet taken. The transparent index is written
// through cfg_wr_en / cfg_wr_data; the user must do so only while idle (not enforced).
module sprite_rle_decoder (
	input  logic           clk,
	input  logic           arst_n,
	srd_code_if.sink       code,
	srd_run_if.source      runs,
	input  logic           cfg_wr_en,
	input  logic [7:0]     cfg_wr_data
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           fin_s1;
	logic           res_valid_q;
	srd_pkg::run_t  res_q;
	logic [7:0]     trans_idx_q;
	logic           step;
	logic           emit;
	srd_pkg::run_t  res;

	assign step       = valid_s1 && (!res_valid_q || runs.ready);
	assign code.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code.ready) begin
			valid_s1 <= code.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code.ready && code.valid) begin
			byte_s1 <= code.code_byte;
			fin_s1  <= code.final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_idx_q <= '0;
		end else if (cfg_wr_en) begin
			trans_idx_q <= cfg_wr_data;
		end
	end

	srd_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.code_byte         (byte_s1),
		.final_byte        (fin_s1),
		.transparent_index (trans_idx_q),
		.emit              (emit),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && emit) begin
			res_valid_q <= 1'b1;
		end else if (runs.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	assign runs.valid       = res_valid_q;
	assign runs.pixel_value = res_q.pixel_value;
	assign runs.run_length  = res_q.run_length;
	assign runs.status      = res_q.status;
	assign runs.image_done  = res_q.image_done;

endmodule
